// ===== src/tlex_pkg.sv =====
// ----------------------------------------------------------------------------
// Token lexer package
// Shared types, token kind codes, keyword table and helper functions.
// ----------------------------------------------------------------------------
package tlex_pkg;

    localparam int unsigned DEF_MAX_TOKEN_LEN  = 64;
    localparam int unsigned DEF_POSITION_WIDTH = 16;

    localparam int unsigned OUT_POS_W = 16;
    localparam int unsigned OUT_LEN_W = 7;

    localparam logic [3:0] KIND_TEXT      = 4'd0;
    localparam logic [3:0] KIND_EOF       = 4'd1;
    localparam logic [3:0] KIND_DASH      = 4'd2;
    localparam logic [3:0] KIND_SEMI      = 4'd3;
    localparam logic [3:0] KIND_COMMA     = 4'd4;
    localparam logic [3:0] KIND_EQUAL     = 4'd5;
    localparam logic [3:0] KIND_LPAREN    = 4'd6;
    localparam logic [3:0] KIND_RPAREN    = 4'd7;
    localparam logic [3:0] KIND_ANGLE     = 4'd8;
    localparam logic [3:0] KIND_NUMBER    = 4'd9;
    localparam logic [3:0] KIND_IDENT     = 4'd10;
    localparam logic [3:0] KIND_INVAR     = 4'd11;
    localparam logic [3:0] KIND_VTX       = 4'd12;
    localparam logic [3:0] KIND_OPTYPE    = 4'd13;
    localparam logic [3:0] KIND_WRITE     = 4'd14;
    localparam logic [3:0] KIND_ERROR     = 4'd15;

    localparam logic ERR_ILLEGAL_CHAR   = 1'b0;
    localparam logic ERR_ILLEGAL_NUMBER = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam int unsigned KW_COUNT = 7;
    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        {"input", "_var"}, {"ver", "tex"}, "DIVIDE", "PLUS", "TIMES", "MINUS", "write"
    };
    localparam int unsigned KW_LEN [KW_COUNT] = '{9, 6, 6, 4, 5, 5, 5};

    typedef struct packed {
        logic [3:0]           kind;
        logic [7:0]           byte_value;
        logic [1:0]           operator_code;
        logic                 error_code;
        logic [OUT_POS_W-1:0] line_number;
        logic [OUT_POS_W-1:0] column_number;
        logic [OUT_LEN_W-1:0] token_length;
    } t_result;

    // All results that one source byte causes, in delivery order.
    typedef struct packed {
        logic [1:0]      count;
        t_result [2:0]   res;
    } t_group;

    function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] idx);
        logic [71:0] t;
        int unsigned l;
        t = KW_TEXT[k];
        l = KW_LEN[k];
        kw_char = CH_NUL;
        if (idx < l) begin
            kw_char = t[8*(l-1-idx) +: 8];
        end
    endfunction

    function automatic logic [3:0] kw_kind(input int unsigned k);
        if (k == 0) begin
            kw_kind = KIND_INVAR;
        end else if (k == 1) begin
            kw_kind = KIND_VTX;
        end else if (k == KW_COUNT - 1) begin
            kw_kind = KIND_WRITE;
        end else begin
            kw_kind = KIND_OPTYPE;
        end
    endfunction

    function automatic logic [1:0] kw_op(input int unsigned k);
        kw_op = 2'd0;
        if (k >= 2 && k < KW_COUNT - 1) begin
            kw_op = 2'(k - 2);
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_ident_char(input logic [7:0] b);
        is_ident_char = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"))
                     || (b == "_") || is_digit(b);
    endfunction

    function automatic t_result mk_result(
        input logic [3:0]           kind,
        input logic [7:0]           bv,
        input logic [1:0]           op,
        input logic                 ec,
        input logic [OUT_POS_W-1:0] line,
        input logic [OUT_POS_W-1:0] col,
        input logic [OUT_LEN_W-1:0] len
    );
        t_result r;
        r.kind          = kind;
        r.byte_value    = bv;
        r.operator_code = op;
        r.error_code    = ec;
        r.line_number   = line;
        r.column_number = col;
        r.token_length  = len;
        mk_result = r;
    endfunction

endpackage

// ===== src/tlex_in_if.sv =====
// ----------------------------------------------------------------------------
// Token lexer input channel
// Valid/ready channel that carries one source byte per transfer.
// ----------------------------------------------------------------------------
interface tlex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// ===== src/tlex_out_if.sv =====
// ----------------------------------------------------------------------------
// Token lexer output channel
// Valid/ready channel that carries one token result per transfer.
// ----------------------------------------------------------------------------
interface tlex_out_if;
    logic                            valid;
    logic                            ready;
    logic [3:0]                      kind;
    logic [7:0]                      byte_value;
    logic [1:0]                      operator_code;
    logic                            error_code;
    logic [tlex_pkg::OUT_POS_W-1:0]  line_number;
    logic [tlex_pkg::OUT_POS_W-1:0]  column_number;
    logic [tlex_pkg::OUT_LEN_W-1:0]  token_length;
    logic                            last_of_run;

    modport source (
        output valid, output kind, output byte_value, output operator_code,
        output error_code, output line_number, output column_number,
        output token_length, output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input byte_value, input operator_code,
        input error_code, input line_number, input column_number,
        input token_length, input last_of_run, output ready
    );
endinterface

// ===== src/tlex_core.sv =====
// ----------------------------------------------------------------------------
// Token lexer core
// Holds the scanner state and computes, for the byte being taken, the next
// state and the group of results that the byte causes.
// ----------------------------------------------------------------------------
module tlex_core #(
    parameter int unsigned MAX_TOKEN_LEN  = tlex_pkg::DEF_MAX_TOKEN_LEN,
    parameter int unsigned POSITION_WIDTH = tlex_pkg::DEF_POSITION_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_char,
    output tlex_pkg::t_group  o_group
);

    localparam int unsigned LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int unsigned PW = POSITION_WIDTH;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_NUMBER  = 3'd1;
    localparam logic [2:0] M_IDENT   = 3'd2;
    localparam logic [2:0] M_SLASH   = 3'd3;
    localparam logic [2:0] M_COMMENT = 3'd4;
    localparam logic [2:0] M_HALTED  = 3'd5;

    localparam logic [PW-1:0] POS_MAX = '1;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TOKEN_LEN);

    logic [2:0]                         r_mode, n_mode;
    logic [PW-1:0]                      r_line, n_line;
    logic [PW-1:0]                      r_col, n_col;
    logic [PW-1:0]                      r_tsc, n_tsc;
    logic [LW-1:0]                      r_len, n_len;
    logic                               r_dot, n_dot;
    logic [tlex_pkg::KW_COUNT-1:0]      r_kw, n_kw;

    logic [tlex_pkg::KW_COUNT-1:0]      kw_hit;
    logic [tlex_pkg::KW_COUNT-1:0]      kw_hit0;
    logic [3:0]                         close_kind;
    logic [1:0]                         close_op;
    logic [PW-1:0]                      col_sat;
    logic [PW-1:0]                      line_sat;
    logic [LW-1:0]                      len_sat;
    logic [3:0]                         punct_kind;
    logic                               do_idle;
    logic                               blank;
    tlex_pkg::t_group                   grp;

    assign col_sat  = (r_col == POS_MAX) ? r_col : r_col + PW'(1);
    assign line_sat = (r_line == POS_MAX) ? r_line : r_line + PW'(1);
    assign len_sat  = (r_len == LEN_MAX) ? r_len : r_len + LW'(1);
    assign blank    = (i_char == tlex_pkg::CH_SPACE) || (i_char == tlex_pkg::CH_TAB)
                   || (i_char == tlex_pkg::CH_FF) || (i_char == tlex_pkg::CH_BS)
                   || (i_char == tlex_pkg::CH_CR);

    always_comb begin
        for (int unsigned k = 0; k < tlex_pkg::KW_COUNT; k++) begin
            kw_hit[k]  = (r_len < LW'(tlex_pkg::KW_LEN[k]))
                      && (tlex_pkg::kw_char(k, r_len[3:0]) == i_char);
            kw_hit0[k] = (tlex_pkg::kw_char(k, 4'd0) == i_char);
        end
    end

    always_comb begin
        close_kind = tlex_pkg::KIND_IDENT;
        close_op   = 2'd0;
        for (int k = tlex_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (r_kw[k] && (r_len == LW'(tlex_pkg::KW_LEN[k]))) begin
                close_kind = tlex_pkg::kw_kind(k);
                close_op   = tlex_pkg::kw_op(k);
            end
        end
        if (r_mode == M_NUMBER) begin
            close_kind = tlex_pkg::KIND_NUMBER;
            close_op   = 2'd0;
        end
    end

    always_comb begin
        unique case (i_char)
            "-":     punct_kind = tlex_pkg::KIND_DASH;
            ";":     punct_kind = tlex_pkg::KIND_SEMI;
            ",":     punct_kind = tlex_pkg::KIND_COMMA;
            "=":     punct_kind = tlex_pkg::KIND_EQUAL;
            "(":     punct_kind = tlex_pkg::KIND_LPAREN;
            ")":     punct_kind = tlex_pkg::KIND_RPAREN;
            ">":     punct_kind = tlex_pkg::KIND_ANGLE;
            default: punct_kind = tlex_pkg::KIND_TEXT;
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_tsc   = r_tsc;
        n_len   = r_len;
        n_dot   = r_dot;
        n_kw    = r_kw;
        grp     = '0;
        do_idle = 1'b0;

        unique case (r_mode)
            M_HALTED: begin
            end
            M_NUMBER, M_IDENT: begin
                if ((r_mode == M_NUMBER) ? (tlex_pkg::is_digit(i_char)
                                            || (i_char == tlex_pkg::CH_DOT))
                                         : tlex_pkg::is_ident_char(i_char)) begin
                    n_col = col_sat;
                    if ((r_mode == M_NUMBER) && (i_char == tlex_pkg::CH_DOT) && r_dot) begin
                        grp.res[0] = tlex_pkg::mk_result(tlex_pkg::KIND_ERROR, i_char, 2'd0,
                            tlex_pkg::ERR_ILLEGAL_NUMBER, tlex_pkg::OUT_POS_W'(r_line),
                            tlex_pkg::OUT_POS_W'(col_sat), '0);
                        grp.count  = 2'd1;
                        n_mode     = M_HALTED;
                    end else begin
                        if (r_mode == M_NUMBER) begin
                            n_dot = r_dot || (i_char == tlex_pkg::CH_DOT);
                        end else begin
                            n_kw = r_kw & kw_hit;
                        end
                        n_len      = len_sat;
                        grp.res[0] = tlex_pkg::mk_result(tlex_pkg::KIND_TEXT, i_char, 2'd0,
                            tlex_pkg::ERR_ILLEGAL_CHAR, tlex_pkg::OUT_POS_W'(r_line),
                            tlex_pkg::OUT_POS_W'(col_sat), '0);
                        grp.count  = 2'd1;
                    end
                end else begin
                    grp.res[0] = tlex_pkg::mk_result(close_kind, 8'd0, close_op,
                        tlex_pkg::ERR_ILLEGAL_CHAR, tlex_pkg::OUT_POS_W'(r_line),
                        tlex_pkg::OUT_POS_W'(r_tsc), tlex_pkg::OUT_LEN_W'(r_len));
                    grp.count  = 2'd1;
                    do_idle    = 1'b1;
                end
            end
            M_SLASH: begin
                if (i_char == tlex_pkg::CH_SLASH) begin
                    n_col  = col_sat;
                    n_mode = M_COMMENT;
                end else begin
                    grp.res[0] = tlex_pkg::mk_result(tlex_pkg::KIND_ERROR, tlex_pkg::CH_SLASH,
                        2'd0, tlex_pkg::ERR_ILLEGAL_CHAR, tlex_pkg::OUT_POS_W'(r_line),
                        tlex_pkg::OUT_POS_W'(r_tsc), '0);
                    grp.count  = 2'd1;
                    do_idle    = 1'b1;
                end
            end
            M_COMMENT: begin
                if ((i_char == tlex_pkg::CH_NL) || (i_char == tlex_pkg::CH_NUL)) begin
                    do_idle = 1'b1;
                end else begin
                    n_col = col_sat;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            n_mode = M_IDLE;
            if (blank) begin
                n_col = col_sat;
            end else if (i_char == tlex_pkg::CH_NL) begin
                n_col  = '0;
                n_line = line_sat;
            end else begin
                n_col = col_sat;
                if (i_char == tlex_pkg::CH_NUL) begin
                    grp.res[grp.count] = tlex_pkg::mk_result(tlex_pkg::KIND_EOF, 8'd0, 2'd0,
                        tlex_pkg::ERR_ILLEGAL_CHAR, tlex_pkg::OUT_POS_W'(r_line),
                        tlex_pkg::OUT_POS_W'(col_sat), '0);
                    grp.res[grp.count + 2'd1] = grp.res[grp.count];
                    grp.count = grp.count + 2'd2;
                    n_mode    = M_HALTED;
                end else if (i_char == tlex_pkg::CH_SLASH) begin
                    n_tsc  = col_sat;
                    n_mode = M_SLASH;
                end else if (punct_kind != tlex_pkg::KIND_TEXT) begin
                    grp.res[grp.count] = tlex_pkg::mk_result(punct_kind, i_char, 2'd0,
                        tlex_pkg::ERR_ILLEGAL_CHAR, tlex_pkg::OUT_POS_W'(r_line),
                        tlex_pkg::OUT_POS_W'(col_sat), '0);
                    grp.count = grp.count + 2'd1;
                end else if (tlex_pkg::is_ident_char(i_char)
                             || (i_char == tlex_pkg::CH_DOT)) begin
                    if (tlex_pkg::is_digit(i_char) || (i_char == tlex_pkg::CH_DOT)) begin
                        n_mode = M_NUMBER;
                        n_dot  = (i_char == tlex_pkg::CH_DOT);
                    end else begin
                        n_mode = M_IDENT;
                        n_kw   = kw_hit0;
                    end
                    n_tsc = col_sat;
                    n_len = LW'(1);
                    grp.res[grp.count] = tlex_pkg::mk_result(tlex_pkg::KIND_TEXT, i_char, 2'd0,
                        tlex_pkg::ERR_ILLEGAL_CHAR, tlex_pkg::OUT_POS_W'(r_line),
                        tlex_pkg::OUT_POS_W'(col_sat), '0);
                    grp.count = grp.count + 2'd1;
                end else begin
                    grp.res[grp.count] = tlex_pkg::mk_result(tlex_pkg::KIND_ERROR, i_char, 2'd0,
                        tlex_pkg::ERR_ILLEGAL_CHAR, tlex_pkg::OUT_POS_W'(r_line),
                        tlex_pkg::OUT_POS_W'(col_sat), '0);
                    grp.count = grp.count + 2'd1;
                end
            end
        end
    end

    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= PW'(1);
            r_col  <= '0;
            r_tsc  <= '0;
            r_len  <= '0;
            r_dot  <= 1'b0;
            r_kw   <= '1;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_tsc  <= n_tsc;
            r_len  <= n_len;
            r_dot  <= n_dot;
            r_kw   <= n_kw;
        end
    end

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALTED) |=> (r_mode == M_HALTED))
        else $error("Lexer left the halted state without a reset.");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALTED) |-> (o_group.count == 2'd0))
        else $error("Halted lexer produced a result.");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("Line counter reached zero.");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("Token length exceeded its saturation limit.");

endmodule

// ===== src/token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// Token lexer unit
// Streaming lexer: one source byte in per transfer, token results out.
// ----------------------------------------------------------------------------
// A source byte is taken in every cycle in which one is offered and the result
// queue has room; the lexer state updates in the same cycle and the results of
// that byte are stored as one group in a two-group queue, whose registers hold
// them until the output reaches them. The output side delivers one result per
// cycle while the token channel is ready; a byte that causes two or three
// results (a lone slash or a closed token followed by another result, or end of
// input, which gives three when it also closes a token or follows a lone slash)
// takes one output transfer per result, which the queue absorbs before input is held.
module token_lexer_unit #(
    parameter int unsigned MAX_TOKEN_LEN  = tlex_pkg::DEF_MAX_TOKEN_LEN,
    parameter int unsigned POSITION_WIDTH = tlex_pkg::DEF_POSITION_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlex_in_if.sink    i_char,
    tlex_out_if.source o_tok
);

    tlex_pkg::t_group   grp;
    tlex_pkg::t_group   r_grp [2];
    tlex_pkg::t_group   head;
    tlex_pkg::t_result  cur;
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_fill, n_fill;
    logic [1:0]         r_sub;
    logic               take;
    logic               push;
    logic               fire;
    logic               pop;
    logic               last;

    assign i_char.ready = (r_fill != 2'd2);
    assign take         = i_char.valid && i_char.ready;

    tlex_core #(
        .MAX_TOKEN_LEN  (MAX_TOKEN_LEN),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (i_char.char_in),
        .o_group (grp)
    );

    assign push   = take && (grp.count != 2'd0);
    assign head   = r_grp[r_rd_ptr];
    assign cur    = head.res[r_sub];
    assign last   = (r_sub == head.count - 2'd1);
    assign fire   = o_tok.valid && o_tok.ready;
    assign pop    = fire && last;
    assign n_fill = r_fill + {1'b0, push} - {1'b0, pop};

    assign o_tok.valid         = (r_fill != 2'd0);
    assign o_tok.kind          = cur.kind;
    assign o_tok.byte_value    = cur.byte_value;
    assign o_tok.operator_code = cur.operator_code;
    assign o_tok.error_code    = cur.error_code;
    assign o_tok.line_number   = cur.line_number;
    assign o_tok.column_number = cur.column_number;
    assign o_tok.token_length  = cur.token_length;
    assign o_tok.last_of_run   = last;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_grp[r_wr_ptr] <= grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
            r_sub    <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 2'd0;
            end else if (fire) begin
                r_sub <= r_sub + 2'd1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("Result queue overfilled.");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid |-> ((head.count != 2'd0) && (r_sub < head.count)))
        else $error("Output points past the results of the head group.");

    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd0 || r_fill == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("Queue pointers disagree with the fill count.");

endmodule

// ===== tb/tb_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// Token lexer unit testbench
// Drives source bytes through the input channel with random gaps and stalls
// the token channel at random. Every accepted byte is run through a local
// lexer that computes the tokens it causes, and each token transfer is
// checked field by field against the oldest outstanding prediction. The run
// covers punctuation, blanks, illegal bytes, slashes, comments, keywords and
// near misses, numbers, length saturation, and ends with one randomly chosen
// way of halting the lexer.
// ----------------------------------------------------------------------------
module tb_token_lexer_unit;

    localparam int unsigned POS_MAX = (1 << tlex_pkg::DEF_POSITION_WIDTH) - 1;
    localparam int unsigned LEN_MAX = tlex_pkg::DEF_MAX_TOKEN_LEN;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_DIVIDE = 2'd0;
    localparam logic [1:0] OP_PLUS   = 2'd1;
    localparam logic [1:0] OP_TIMES  = 2'd2;
    localparam logic [1:0] OP_MINUS  = 2'd3;
    localparam logic       NO_ERROR  = 1'b0;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_IDENT,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_HALTED
    } t_scan;

    typedef struct packed {
        logic [3:0]                     kind;
        logic [7:0]                     byte_value;
        logic [1:0]                     operator_code;
        logic                           error_code;
        logic [tlex_pkg::OUT_POS_W-1:0] line_number;
        logic [tlex_pkg::OUT_POS_W-1:0] column_number;
        logic [tlex_pkg::OUT_LEN_W-1:0] token_length;
        logic                           last_of_run;
    } t_lex_token;

    logic clk;
    logic rst_n;

    tlex_in_if  char_bus ();
    tlex_out_if tok_bus ();

    token_lexer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_bus),
        .o_tok   (tok_bus)
    );

    string kw_words [7] = '{{"input", "_var"}, {"ver", "tex"}, "DIVIDE", "PLUS", "TIMES",
                            "MINUS", "write"};
    string word_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string punct_chars  = "-;,=()>";
    string sep_chars    = " ;,()\n>=-";

    t_scan       scan_st   = SCAN_IDLE;
    int unsigned cur_line  = 1;
    int unsigned cur_col   = 0;
    int unsigned tok_col   = 0;
    int unsigned tok_len   = 0;
    bit          dot_flag  = 1'b0;
    logic [6:0]  kw_live   = 7'h7F;

    t_lex_token  step_toks[$];
    t_lex_token  pending_tokens[$];
    int unsigned mismatch_count = 0;
    bit          src_hurry = 1'b0;
    bit          snk_hurry = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic bit is_blank(input logic [7:0] b);
        return (b == tlex_pkg::CH_SPACE) || (b == tlex_pkg::CH_TAB) || (b == tlex_pkg::CH_FF)
            || (b == tlex_pkg::CH_BS) || (b == tlex_pkg::CH_CR);
    endfunction

    function automatic bit numeral(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic bit word_char(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_")
            || numeral(b);
    endfunction

    function automatic void bump_col();
        if (cur_col < POS_MAX) begin
            cur_col++;
        end
    endfunction

    function automatic void push_tok(input logic [3:0] kind, input logic [7:0] bv,
                                     input logic [1:0] op, input logic ec,
                                     input int unsigned col, input int unsigned len);
        t_lex_token t;
        t.kind          = kind;
        t.byte_value    = bv;
        t.operator_code = op;
        t.error_code    = ec;
        t.line_number   = cur_line[tlex_pkg::OUT_POS_W-1:0];
        t.column_number = col[tlex_pkg::OUT_POS_W-1:0];
        t.token_length  = len[tlex_pkg::OUT_LEN_W-1:0];
        t.last_of_run   = 1'b0;
        step_toks.insert(step_toks.size(), t);
    endfunction

    function automatic void filter_keywords(input logic [7:0] b);
        for (int k = 0; k < 7; k++) begin
            if (tok_len >= kw_words[k].len() || kw_words[k][tok_len] != b) begin
                kw_live[k] = 1'b0;
            end
        end
    endfunction

    function automatic void close_tok();
        logic [3:0] kind;
        logic [1:0] op;
        bit         found;
        kind  = tlex_pkg::KIND_IDENT;
        op    = OP_NONE;
        found = 1'b0;
        if (scan_st == SCAN_NUMBER) begin
            kind = tlex_pkg::KIND_NUMBER;
        end else begin
            for (int k = 0; k < 7; k++) begin
                if (!found && kw_live[k] && tok_len == kw_words[k].len()) begin
                    found = 1'b1;
                    case (k)
                        0: kind = tlex_pkg::KIND_INVAR;
                        1: kind = tlex_pkg::KIND_VTX;
                        2: begin kind = tlex_pkg::KIND_OPTYPE; op = OP_DIVIDE; end
                        3: begin kind = tlex_pkg::KIND_OPTYPE; op = OP_PLUS; end
                        4: begin kind = tlex_pkg::KIND_OPTYPE; op = OP_TIMES; end
                        5: begin kind = tlex_pkg::KIND_OPTYPE; op = OP_MINUS; end
                        default: kind = tlex_pkg::KIND_WRITE;
                    endcase
                end
            end
        end
        push_tok(kind, tlex_pkg::CH_NUL, op, NO_ERROR, tok_col, tok_len);
        scan_st = SCAN_IDLE;
    endfunction

    function automatic void lex_fresh(input logic [7:0] b);
        logic [3:0] punct;
        scan_st = SCAN_IDLE;
        if (is_blank(b)) begin
            bump_col();
            return;
        end
        if (b == tlex_pkg::CH_NL) begin
            cur_col = 0;
            if (cur_line < POS_MAX) begin
                cur_line++;
            end
            return;
        end
        bump_col();
        if (b == tlex_pkg::CH_NUL) begin
            push_tok(tlex_pkg::KIND_EOF, tlex_pkg::CH_NUL, OP_NONE, NO_ERROR, cur_col, 0);
            push_tok(tlex_pkg::KIND_EOF, tlex_pkg::CH_NUL, OP_NONE, NO_ERROR, cur_col, 0);
            scan_st = SCAN_HALTED;
            return;
        end
        if (b == tlex_pkg::CH_SLASH) begin
            tok_col = cur_col;
            scan_st = SCAN_SLASH;
            return;
        end
        case (b)
            "-":     punct = tlex_pkg::KIND_DASH;
            ";":     punct = tlex_pkg::KIND_SEMI;
            ",":     punct = tlex_pkg::KIND_COMMA;
            "=":     punct = tlex_pkg::KIND_EQUAL;
            "(":     punct = tlex_pkg::KIND_LPAREN;
            ")":     punct = tlex_pkg::KIND_RPAREN;
            ">":     punct = tlex_pkg::KIND_ANGLE;
            default: punct = tlex_pkg::KIND_TEXT;
        endcase
        if (punct != tlex_pkg::KIND_TEXT) begin
            push_tok(punct, b, OP_NONE, NO_ERROR, cur_col, 0);
        end else if (numeral(b) || b == tlex_pkg::CH_DOT) begin
            scan_st  = SCAN_NUMBER;
            tok_col  = cur_col;
            tok_len  = 1;
            dot_flag = (b == tlex_pkg::CH_DOT);
            push_tok(tlex_pkg::KIND_TEXT, b, OP_NONE, NO_ERROR, cur_col, 0);
        end else if (word_char(b)) begin
            scan_st = SCAN_IDENT;
            tok_col = cur_col;
            tok_len = 0;
            kw_live = 7'h7F;
            filter_keywords(b);
            tok_len = 1;
            push_tok(tlex_pkg::KIND_TEXT, b, OP_NONE, NO_ERROR, cur_col, 0);
        end else begin
            push_tok(tlex_pkg::KIND_ERROR, b, OP_NONE, tlex_pkg::ERR_ILLEGAL_CHAR, cur_col, 0);
        end
    endfunction

    function automatic void lex_byte(input logic [7:0] b);
        t_lex_token t;
        case (scan_st)
            SCAN_HALTED: ;
            SCAN_NUMBER: begin
                if (numeral(b) || b == tlex_pkg::CH_DOT) begin
                    bump_col();
                    if (b == tlex_pkg::CH_DOT && dot_flag) begin
                        push_tok(tlex_pkg::KIND_ERROR, b, OP_NONE,
                                 tlex_pkg::ERR_ILLEGAL_NUMBER, cur_col, 0);
                        scan_st = SCAN_HALTED;
                    end else begin
                        if (b == tlex_pkg::CH_DOT) begin
                            dot_flag = 1'b1;
                        end
                        if (tok_len < LEN_MAX) begin
                            tok_len++;
                        end
                        push_tok(tlex_pkg::KIND_TEXT, b, OP_NONE, NO_ERROR, cur_col, 0);
                    end
                end else begin
                    close_tok();
                    lex_fresh(b);
                end
            end
            SCAN_IDENT: begin
                if (word_char(b)) begin
                    bump_col();
                    filter_keywords(b);
                    if (tok_len < LEN_MAX) begin
                        tok_len++;
                    end
                    push_tok(tlex_pkg::KIND_TEXT, b, OP_NONE, NO_ERROR, cur_col, 0);
                end else begin
                    close_tok();
                    lex_fresh(b);
                end
            end
            SCAN_SLASH: begin
                if (b == tlex_pkg::CH_SLASH) begin
                    bump_col();
                    scan_st = SCAN_COMMENT;
                end else begin
                    push_tok(tlex_pkg::KIND_ERROR, tlex_pkg::CH_SLASH, OP_NONE,
                             tlex_pkg::ERR_ILLEGAL_CHAR, tok_col, 0);
                    lex_fresh(b);
                end
            end
            SCAN_COMMENT: begin
                if (b == tlex_pkg::CH_NL || b == tlex_pkg::CH_NUL) begin
                    lex_fresh(b);
                end else begin
                    bump_col();
                end
            end
            default: lex_fresh(b);
        endcase
        while (step_toks.size() > 0) begin
            t = step_toks.pop_front();
            t.last_of_run = (step_toks.size() == 0);
            pending_tokens.insert(pending_tokens.size(), t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers and checking
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = src_hurry ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.char_in <= b;
        @(posedge clk);
        while (char_bus.ready !== 1'b1) @(posedge clk);
        lex_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] any_word_char();
        return word_chars[$urandom_range(0, word_chars.len() - 1)];
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_token(input t_lex_token got);
        t_lex_token want;
        if (pending_tokens.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected token transfer, expected none, actual kind %0d byte %0d",
                     $time, got.kind, got.byte_value);
        end else begin
            want = pending_tokens.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("byte_value", want.byte_value, got.byte_value);
            compare_field("operator_code", want.operator_code, got.operator_code);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("line_number", want.line_number, got.line_number);
            compare_field("column_number", want.column_number, got.column_number);
            compare_field("token_length", want.token_length, got.token_length);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        end
    endtask

    initial begin : token_sink
        t_lex_token  got;
        bit          fire;
        int unsigned stall;
        tok_bus.ready <= 1'b0;
        stall = 0;
        forever begin
            @(posedge clk);
            fire = (rst_n === 1'b1) && (tok_bus.valid === 1'b1) && (tok_bus.ready === 1'b1);
            got.kind          = tok_bus.kind;
            got.byte_value    = tok_bus.byte_value;
            got.operator_code = tok_bus.operator_code;
            got.error_code    = tok_bus.error_code;
            got.line_number   = tok_bus.line_number;
            got.column_number = tok_bus.column_number;
            got.token_length  = tok_bus.token_length;
            got.last_of_run   = tok_bus.last_of_run;
            @(negedge clk);
            if (fire) begin
                check_token(got);
                stall = snk_hurry ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                tok_bus.ready <= 1'b0;
                stall--;
            end else begin
                tok_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_single_bytes();
        send_text(punct_chars);
        send_byte(tlex_pkg::CH_SPACE);
        send_byte(tlex_pkg::CH_TAB);
        send_byte(tlex_pkg::CH_FF);
        send_byte(tlex_pkg::CH_BS);
        send_byte(tlex_pkg::CH_CR);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(tlex_pkg::CH_NL);
    endtask

    task automatic test_slash_and_comment();
        send_text("/a.5//x\n");
    endtask

    task automatic test_keyword();
        send_text("PLUS;");
    endtask

    task automatic test_random_text();
        logic [7:0]  piece[$];
        logic [7:0]  b;
        int unsigned sent, n, k, pick;
        sent = 0;
        while (sent < 40) begin
            piece.delete();
            if ($urandom_range(0, 11) == 0) src_hurry = !src_hurry;
            if ($urandom_range(0, 11) == 0) snk_hurry = !snk_hurry;
            pick = $urandom_range(0, 15);
            case (pick)
                0, 1, 2: begin
                    k = $urandom_range(0, 6);
                    n = kw_words[k].len();
                    if ($urandom_range(0, 3) == 0) n--;
                    for (int i = 0; i < n; i++) piece.insert(piece.size(), kw_words[k][i]);
                    if ($urandom_range(0, 3) == 0) piece.insert(piece.size(), any_word_char());
                end
                3, 4: begin
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++) piece.insert(piece.size(), any_word_char());
                end
                5, 6: begin
                    n = $urandom_range(1, 6);
                    k = $urandom_range(0, 2 * n);
                    for (int i = 0; i < n; i++) begin
                        if (i == k) piece.insert(piece.size(), tlex_pkg::CH_DOT);
                        piece.insert(piece.size(), 8'($urandom_range("0", "9")));
                    end
                end
                7, 8: piece.insert(piece.size(),
                                   punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
                9: begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) begin
                        case ($urandom_range(0, 4))
                            0:       piece.insert(piece.size(), tlex_pkg::CH_SPACE);
                            1:       piece.insert(piece.size(), tlex_pkg::CH_TAB);
                            2:       piece.insert(piece.size(), tlex_pkg::CH_FF);
                            3:       piece.insert(piece.size(), tlex_pkg::CH_BS);
                            default: piece.insert(piece.size(), tlex_pkg::CH_CR);
                        endcase
                    end
                end
                10: piece.insert(piece.size(), tlex_pkg::CH_NL);
                11: begin
                    piece.insert(piece.size(), tlex_pkg::CH_SLASH);
                    piece.insert(piece.size(), tlex_pkg::CH_SLASH);
                    n = $urandom_range(0, 8);
                    for (int i = 0; i < n; i++) begin
                        b = 8'($urandom_range(1, 255));
                        piece.insert(piece.size(), (b == tlex_pkg::CH_NL) ? tlex_pkg::CH_DOT : b);
                    end
                    piece.insert(piece.size(), tlex_pkg::CH_NL);
                end
                12: begin
                    piece.insert(piece.size(), tlex_pkg::CH_SLASH);
                    piece.insert(piece.size(), 8'($urandom_range(1, 255)));
                end
                13: piece.insert(piece.size(), 8'($urandom_range(128, 255)));
                default: piece.insert(piece.size(), 8'($urandom_range(1, 255)));
            endcase
            if (pick <= 6 && $urandom_range(0, 3) != 0) begin
                piece.insert(piece.size(), sep_chars[$urandom_range(0, sep_chars.len() - 1)]);
            end
            // A second dot would halt the lexer for the rest of the run.
            foreach (piece[i]) begin
                b = piece[i];
                if (b == tlex_pkg::CH_DOT && scan_st == SCAN_NUMBER && dot_flag) begin
                    b = tlex_pkg::CH_SPACE;
                end
                send_byte(b);
                sent++;
            end
        end
        src_hurry = 1'b0;
        snk_hurry = 1'b0;
    endtask

    task automatic test_saturation();
        src_hurry = 1'b1;
        snk_hurry = 1'b1;
        send_text(kw_words[0]);
        repeat (57) send_byte(any_word_char());
        send_byte(";");
        repeat (20) send_byte(8'($urandom_range("0", "9")));
        send_byte(",");
        send_text("q(\n- ");
        src_hurry = 1'b0;
        snk_hurry = 1'b0;
    endtask

    task automatic test_end_of_input();
        case ($urandom_range(0, 3))
            0: begin
                send_text("x//c");
                send_byte(tlex_pkg::CH_NUL);
            end
            1: begin
                send_text("42");
                send_byte(tlex_pkg::CH_NUL);
            end
            2: begin
                send_byte(tlex_pkg::CH_SLASH);
                send_byte(tlex_pkg::CH_NUL);
            end
            default: send_text("1.2.");
        endcase
        // The lexer is halted now and must stay silent.
        send_text("ab;");
        send_byte(tlex_pkg::CH_NUL);
        send_byte(8'hFF);
    endtask

    initial begin
        char_bus.valid   <= 1'b0;
        char_bus.char_in <= tlex_pkg::CH_NUL;
        rst_n            <= 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_single_bytes();
        test_slash_and_comment();
        test_keyword();
        test_random_text();
        test_saturation();
        test_end_of_input();

        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (pending_tokens.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== token_lexer_unit.f =====
src/tlex_pkg.sv
src/tlex_in_if.sv
src/tlex_out_if.sv
src/tlex_core.sv
src/token_lexer_unit.sv
tb/tb_token_lexer_unit.sv
